### src/ft12_pkg.sv
// shared types and constants for the ft1.2 frame deframer
`default_nettype none
package ft12_pkg;

  localparam logic [7:0] START_VAR = 8'h68;
  localparam logic [7:0] START_FIX = 8'h10;
  localparam logic [7:0] STOP_BYTE = 8'h16;
  localparam logic [7:0] SC_ACK    = 8'hE5;
  localparam logic [7:0] SC_NACK   = 8'hA2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LENGTH   = 2'd1;
  localparam logic [1:0] ST_FRAMING  = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  localparam logic [1:0] FT_VARIABLE = 2'd0;
  localparam logic [1:0] FT_FIXED    = 2'd1;
  localparam logic [1:0] FT_SINGLE   = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [1:0]  frame_type;
    logic [3:0]  function_code;
    logic        primary;
    logic        count_valid;
    logic        count_bit;
    logic        flow_control;
    logic        access_demand;
    logic        direction;
    logic [15:0] link_address;
  } result_t;

endpackage
`default_nettype wire

### src/ft12_in_stage.sv
// input register for received line bytes
`default_nettype none
module ft12_in_stage (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] rx_byte,
  input  wire        advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // take a new byte when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule
`default_nettype wire

### src/ft12_parser.sv
// frame state machine, checksum and field decode for one byte per cycle while step is high
`default_nettype none
module ft12_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  [1:0]            address_length,
  input  wire                   step,
  input  wire  [7:0]            rx_byte,
  output logic                  res_valid,
  output ft12_pkg::result_t     res
);

  localparam logic [3:0] PH_HUNT   = 4'd0;
  localparam logic [3:0] PH_LEN1   = 4'd1;
  localparam logic [3:0] PH_LEN2   = 4'd2;
  localparam logic [3:0] PH_START2 = 4'd3;
  localparam logic [3:0] PH_CTRL   = 4'd4;
  localparam logic [3:0] PH_ADDR   = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CHK    = 4'd7;
  localparam logic [3:0] PH_STOP   = 4'd8;

  logic [3:0]  phase, phase_next;
  logic        is_variable, is_variable_next;
  logic [7:0]  length_field, length_field_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  checksum_acc, checksum_acc_next;
  logic [7:0]  control_byte, control_byte_next;
  logic [15:0] address_acc, address_acc_next;
  logic [1:0]  address_count, address_count_next;

  logic [1:0]  alen;
  logic [7:0]  alen_w;
  logic [7:0]  sum;
  logic [1:0]  count_inc;
  logic        prm;
  logic        end_frame;
  logic [1:0]  end_status;
  logic        after_addr_data;
  ft12_pkg::result_t end_res;

  // a register value of three behaves as two
  assign alen   = (address_length == 2'd3) ? 2'd2 : address_length;
  assign alen_w = {6'd0, alen};
  assign sum    = checksum_acc + rx_byte;
  assign count_inc = address_count + 2'd1;
  assign after_addr_data = is_variable && (bytes_left != 8'd0);
  assign prm = control_byte[6];

  // frame end fields come from the registered control byte and address
  always_comb begin
    end_res               = '0;
    end_res.kind          = ft12_pkg::KIND_END;
    end_res.status        = end_status;
    end_res.frame_type    = is_variable ? ft12_pkg::FT_VARIABLE : ft12_pkg::FT_FIXED;
    end_res.function_code = control_byte[3:0];
    end_res.primary       = prm;
    end_res.count_valid   = prm & control_byte[4];
    end_res.count_bit     = prm & control_byte[5];
    end_res.flow_control  = !prm & control_byte[4];
    end_res.access_demand = !prm & control_byte[5];
    end_res.direction     = control_byte[7];
    end_res.link_address  = address_acc;
  end

  always_comb begin
    phase_next         = phase;
    is_variable_next   = is_variable;
    length_field_next  = length_field;
    bytes_left_next    = bytes_left;
    checksum_acc_next  = checksum_acc;
    control_byte_next  = control_byte;
    address_acc_next   = address_acc;
    address_count_next = address_count;
    end_frame          = 1'b0;
    end_status         = ft12_pkg::ST_OK;
    res_valid          = 1'b0;
    res                = '0;

    case (phase)
      PH_LEN1: begin
        length_field_next = rx_byte;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        if (rx_byte != length_field) begin
          end_frame  = 1'b1;
          end_status = ft12_pkg::ST_LENGTH;
        end else begin
          phase_next = PH_START2;
        end
      end
      PH_START2: begin
        if (rx_byte != ft12_pkg::START_VAR) begin
          end_frame  = 1'b1;
          end_status = ft12_pkg::ST_FRAMING;
        end else if (length_field < alen_w + 8'd1) begin
          end_frame  = 1'b1;
          end_status = ft12_pkg::ST_LENGTH;
        end else begin
          bytes_left_next = length_field - 8'd1 - alen_w;
          phase_next      = PH_CTRL;
        end
      end
      PH_CTRL: begin
        control_byte_next = rx_byte;
        checksum_acc_next = sum;
        if (alen == 2'd0) begin
          phase_next = after_addr_data ? PH_DATA : PH_CHK;
        end else begin
          phase_next = PH_ADDR;
        end
      end
      PH_ADDR: begin
        checksum_acc_next = sum;
        if (address_count == 2'd0) begin
          address_acc_next = address_acc | {8'd0, rx_byte};
        end else begin
          address_acc_next = address_acc | {rx_byte, 8'd0};
        end
        address_count_next = count_inc;
        if (count_inc >= alen || count_inc >= 2'd2) begin
          phase_next = after_addr_data ? PH_DATA : PH_CHK;
        end
      end
      PH_DATA: begin
        checksum_acc_next = sum;
        bytes_left_next   = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_CHK;
        end
        res_valid     = 1'b1;
        res.kind      = ft12_pkg::KIND_DATA;
        res.data_byte = rx_byte;
      end
      PH_CHK: begin
        if (rx_byte != checksum_acc) begin
          end_frame  = 1'b1;
          end_status = ft12_pkg::ST_CHECKSUM;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_STOP: begin
        end_frame  = 1'b1;
        end_status = (rx_byte == ft12_pkg::STOP_BYTE) ? ft12_pkg::ST_OK
                                                       : ft12_pkg::ST_FRAMING;
      end
      default: begin
        // hunting, also for unused phase codes
        phase_next = PH_HUNT;
        if (rx_byte == ft12_pkg::START_VAR || rx_byte == ft12_pkg::START_FIX ||
            rx_byte == ft12_pkg::SC_ACK || rx_byte == ft12_pkg::SC_NACK) begin
          length_field_next  = 8'd0;
          bytes_left_next    = 8'd0;
          checksum_acc_next  = 8'd0;
          control_byte_next  = 8'd0;
          address_acc_next   = 16'd0;
          address_count_next = 2'd0;
          is_variable_next   = 1'b0;
          if (rx_byte == ft12_pkg::START_VAR) begin
            is_variable_next = 1'b1;
            phase_next       = PH_LEN1;
          end else if (rx_byte == ft12_pkg::START_FIX) begin
            phase_next = PH_CTRL;
          end else begin
            res_valid      = 1'b1;
            res.kind       = ft12_pkg::KIND_END;
            res.data_byte  = rx_byte;
            res.status     = ft12_pkg::ST_OK;
            res.frame_type = ft12_pkg::FT_SINGLE;
          end
        end
      end
    endcase

    if (end_frame) begin
      res_valid  = 1'b1;
      res        = end_res;
      phase_next = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      is_variable   <= 1'b0;
      length_field  <= 8'd0;
      bytes_left    <= 8'd0;
      checksum_acc  <= 8'd0;
      control_byte  <= 8'd0;
      address_acc   <= 16'd0;
      address_count <= 2'd0;
    end else if (step) begin
      phase         <= phase_next;
      is_variable   <= is_variable_next;
      length_field  <= length_field_next;
      bytes_left    <= bytes_left_next;
      checksum_acc  <= checksum_acc_next;
      control_byte  <= control_byte_next;
      address_acc   <= address_acc_next;
      address_count <= address_count_next;
    end
  end

endmodule
`default_nettype wire

### src/ft12_out_stage.sv
// result register towards the consumer
`default_nettype none
module ft12_out_stage (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     load,
  input  wire ft12_pkg::result_t  res_in,
  input  wire                     out_ready,
  output logic                    out_valid,
  output ft12_pkg::result_t       res_out
);

  logic out_valid_next;

  assign out_valid_next = load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule
`default_nettype wire

### src/ft12_frame_deframer.sv
// top level of the ft1.2 frame deframer
// ft1.2 link layer receiver. Line bytes come in on rx_byte one request at a
// time; bytes outside a frame are dropped until a start byte is seen (0x68
// variable frame, 0x10 fixed frame, 0xe5/0xa2 single character frame). Each
// payload byte of a variable frame is passed on as a kind 0 result as it
// arrives, and each frame ends with one kind 1 result carrying the status,
// frame type, decoded control field and link address. A frame is dropped at
// its first error and hunting resumes with the next byte. Throughput is one
// byte per clock while the consumer keeps up: the byte sits in an input
// register, the frame state machine and byte-sum checksum are updated when
// the byte leaves that register, and any result is loaded into the result
// register at that same update, from which it drives the outputs. While a
// result waits in the result register the held byte is not processed, so the
// input side takes at most one more byte and then stalls until the result is
// taken.
// address_length is written through the cfg port and should only change
// while no frame is in progress; its reset value is 1.
`default_nettype none
module ft12_frame_deframer (
  input  wire         clk,
  input  wire         rst,
  // configuration write
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_data,
  // line byte input
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  rx_byte,
  // result output
  output logic        out_valid,
  input  wire         out_ready,
  output logic        kind,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic [1:0]  frame_type,
  output logic [3:0]  function_code,
  output logic        primary,
  output logic        count_valid,
  output logic        count_bit,
  output logic        flow_control,
  output logic        access_demand,
  output logic        direction,
  output logic [15:0] link_address
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              advance;
  logic              res_valid;
  logic [1:0]        address_length;
  ft12_pkg::result_t res;
  ft12_pkg::result_t res_q;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_length <= 2'd1;
    end else if (cfg_valid) begin
      address_length <= cfg_data;
    end
  end

  // the held byte is processed once the result register has room
  assign advance = held_valid && (!out_valid || out_ready);

  ft12_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ft12_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .address_length (address_length),
    .step           (advance),
    .rx_byte        (held_byte),
    .res_valid      (res_valid),
    .res            (res)
  );

  ft12_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  // unpack the result register onto the ports
  assign kind          = res_q.kind;
  assign data_byte     = res_q.data_byte;
  assign status        = res_q.status;
  assign frame_type    = res_q.frame_type;
  assign function_code = res_q.function_code;
  assign primary       = res_q.primary;
  assign count_valid   = res_q.count_valid;
  assign count_bit     = res_q.count_bit;
  assign flow_control  = res_q.flow_control;
  assign access_demand = res_q.access_demand;
  assign direction     = res_q.direction;
  assign link_address  = res_q.link_address;

`ifndef SYNTH
  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // payload results carry nothing but the byte
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ft12_pkg::KIND_DATA |->
      status == ft12_pkg::ST_OK && frame_type == ft12_pkg::FT_VARIABLE &&
      link_address == 16'd0 && function_code == 4'd0)
    else $error("payload result with frame fields set");

  // single character frames are always good ack or nack codes
  a_single_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_type == ft12_pkg::FT_SINGLE |->
      kind == ft12_pkg::KIND_END && status == ft12_pkg::ST_OK &&
      (data_byte == ft12_pkg::SC_ACK || data_byte == ft12_pkg::SC_NACK))
    else $error("malformed single character result");

  // primary and secondary control bits are never both reported
  a_prm_split: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == ft12_pkg::KIND_END |->
      !((count_valid || count_bit) && (flow_control || access_demand)) &&
      (primary || !(count_valid || count_bit)))
    else $error("control field decode mixes station roles");
`endif

endmodule
`default_nettype wire
